// ----- hdl/i2a_pkg.sv -----
// Shared types and constants for the integer to decimal ASCII converter.
package i2a_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

    // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SH  = 35;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [IDX_W-1:0]   t_idx;

    typedef struct packed {
        logic load;
        logic divide;
        logic put_sign;
        logic put_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic q_zero;
        logic idx_zero;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/i2a_in_if.sv -----
// Input channel: one signed 32-bit value per transfer.
interface i2a_in_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- hdl/i2a_out_if.sv -----
// Output channel: one ASCII character per transfer, with end-of-text flag.
interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- hdl/i2a_datapath.sv -----
// Datapath: magnitude register, divide-by-ten step, digit buffer, output register.
module i2a_datapath
    import i2a_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [VALUE_W-1:0]   i_value,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    i2a_out_if.source            o_out
);

    logic [VALUE_W-1:0]   r_mag;
    logic                 r_neg;
    t_idx                 r_cnt;
    t_digit               r_buf [MAX_DIGITS];
    logic                 r_valid;
    logic [CHAR_W-1:0]    r_char;
    logic                 r_last;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    t_digit               q10_lo;
    t_digit               digit;
    logic [VALUE_W-1:0]   mag_in;

    assign mag_in = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    assign prod   = {{VALUE_W{1'b0}}, r_mag} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot   = VALUE_W'(prod[2*VALUE_W-1:RECIP_SH]);
    // low nibble of 10*q is enough: remainder stays below ten
    assign q10_lo = t_digit'({quot[0], 3'b000}) + t_digit'({quot[2:0], 1'b0});
    assign digit  = r_mag[DIGIT_W-1:0] - q10_lo;

    assign o_status.neg      = r_neg;
    assign o_status.q_zero   = (quot == '0);
    assign o_status.idx_zero = (r_cnt == '0);
    assign o_status.out_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= mag_in;
            r_neg <= i_value[VALUE_W-1];
        end else if (i_cmd.divide) begin
            r_mag <= quot;
        end
        if (i_cmd.divide) begin
            r_buf[r_cnt] <= digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.divide && (quot != '0)) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.put_digit && (r_cnt != '0)) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.put_sign || i_cmd.put_digit) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put_sign) begin
            r_char <= CHAR_MINUS;
            r_last <= 1'b0;
        end else if (i_cmd.put_digit) begin
            r_char <= CHAR_ZERO + CHAR_W'(r_buf[r_cnt]);
            r_last <= (r_cnt == '0);
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

endmodule

// ----- hdl/i2a_ctrl.sv -----
// Controller: sequences load, digit extraction and character output.
module i2a_ctrl
    import i2a_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    t_state r_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:   o_cmd.load      = i_in_valid;
            ST_DIVIDE: o_cmd.divide    = 1'b1;
            ST_SIGN:   o_cmd.put_sign  = i_status.out_free;
            ST_DIGITS: o_cmd.put_digit = i_status.out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) r_state <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    if (i_status.q_zero) r_state <= i_status.neg ? ST_SIGN : ST_DIGITS;
                end
                ST_SIGN: begin
                    if (i_status.out_free) r_state <= ST_DIGITS;
                end
                ST_DIGITS: begin
                    if (i_status.out_free && i_status.idx_zero) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- hdl/int32_to_decimal_ascii_top.sv -----
// Converts a signed 32-bit value to its decimal ASCII text, one character per
// output transfer, most significant first, minus sign leading negative values and
// last set on the final digit. A value is loaded, then its digits are extracted,
// one divide-by-ten per cycle through a single reciprocal multiplier, least
// significant digit first, into a ten-entry buffer; then one character (the sign,
// then the digits) is output per cycle while the sink is ready.
// The next value is taken while the final character still waits in the output
// register.
module int32_to_decimal_ascii_top
    import i2a_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2a_in_if.sink    i_in,
    i2a_out_if.source o_out
);

    t_cmd    cmd;
    t_status status;

    i2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    i2a_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_value  (VALUE_W'(i_in.value)),
        .i_cmd    (cmd),
        .o_status (status),
        .o_out    (o_out)
    );

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the signed 32-bit to decimal ASCII converter.
module tb_top;
    import i2a_pkg::*;

    localparam int unsigned RADIX     = 10;
    localparam int          N_RANDOM  = 90;
    localparam int          HOLD_LEN  = 400;
    localparam int          DRAIN_CYC = 40;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_text_char;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    i2a_in_if  in_ch ();
    i2a_out_if out_ch ();

    int32_to_decimal_ascii_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic signed [VALUE_W-1:0] value_q[$];
    t_text_char                text_q[$];

    int   n_total   = 0;
    int   n_sent    = 0;
    logic in_taken  = 1'b0;
    logic failed    = 1'b0;
    int   hold_left = 0;
    logic hold_used = 1'b0;
    int   tx_idle;
    int   rx_idle;

    always #2 i_clk = ~i_clk;

    // Decimal text of one value, sign first, magnitude taken at 33 bits.
    function automatic void expand_decimal(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W:0]   mag;
        logic [DIGIT_W-1:0] dig[MAX_DIGITS];
        int                 n;
        mag = v[VALUE_W-1] ? -{v[VALUE_W-1], v} : {1'b0, v};
        n = 0;
        do begin
            dig[n] = DIGIT_W'(mag % RADIX);
            n++;
            mag = mag / RADIX;
        end while (mag != 0);
        if (v[VALUE_W-1]) begin
            text_q.push_back('{character: CHAR_MINUS, last: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            text_q.push_back('{character: CHAR_ZERO + CHAR_W'(dig[i]), last: (i == 0)});
        end
    endfunction

    // Idle rates by progress: sender light / receiver heavy, then swapped, then none.
    always_comb begin
        if (n_sent < 40) begin
            tx_idle = 14;
            rx_idle = 51;
        end else if (n_sent < 80) begin
            tx_idle = 51;
            rx_idle = 14;
        end else begin
            tx_idle = 0;
            rx_idle = 0;
        end
    end

    // Input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_taken) begin
            if (value_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
                in_ch.valid <= 1'b1;
                in_ch.value <= value_q.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // One long receiver hold-off so the converter backs up into its input
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_used && n_sent >= 12) begin
            hold_left <= HOLD_LEN;
            hold_used <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && (hold_left == 0) && ($urandom_range(99) >= rx_idle);
    end

    // Input acceptance and output checking
    always @(posedge i_clk) begin
        t_text_char exp_c;
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (text_q.size() == 0) begin
                $error("character %0d transfer with no text pending", out_ch.character);
                failed = 1'b1;
            end else begin
                exp_c = text_q.pop_front();
                if (out_ch.character !== exp_c.character) begin
                    $error("character: expected %0d, got %0d",
                           exp_c.character, out_ch.character);
                    failed = 1'b1;
                end
                if (out_ch.last !== exp_c.last) begin
                    $error("last: expected %0d, got %0d", exp_c.last, out_ch.last);
                    failed = 1'b1;
                end
            end
        end
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            expand_decimal(in_ch.value);
            n_sent <= n_sent + 1;
        end
    end

    initial begin
        logic signed [VALUE_W-1:0] v;
        int                        kind;
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;

        // Digit-count boundaries, zero, and both ends of the range
        value_q.push_back(0);
        value_q.push_back(1);
        value_q.push_back(-1);
        value_q.push_back(9);
        value_q.push_back(-9);
        value_q.push_back(10);
        value_q.push_back(-10);
        value_q.push_back(99);
        value_q.push_back(100);
        value_q.push_back(-100);
        value_q.push_back(999999999);
        value_q.push_back(1000000000);
        value_q.push_back(-1000000000);
        value_q.push_back(123456789);
        value_q.push_back(-123456789);
        value_q.push_back(32'sh7FFF_FFFF);
        value_q.push_back(32'sh8000_0000);
        value_q.push_back(32'sh8000_0001);
        value_q.push_back(32'sh5555_5555);
        value_q.push_back(32'shAAAA_AAAA);

        for (int k = 0; k < N_RANDOM; k++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                // spread over all digit counts
                v = $urandom() >> $urandom_range(31);
                if ($urandom_range(1) != 0) begin
                    v = -v;
                end
            end else if (kind < 9) begin
                v = $urandom();
            end else begin
                case ($urandom_range(3))
                    0: v = 32'sh8000_0000;
                    1: v = 32'sh7FFF_FFFF;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            value_q.push_back(v);
        end
        n_total = value_q.size();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (n_sent != n_total || text_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (!failed) begin
            $display("int32_to_decimal_ascii_top test passed");
        end else begin
            $display("int32_to_decimal_ascii_top test failed");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("int32_to_decimal_ascii_top test failed");
        $finish;
    end

endmodule

// ----- int32_to_decimal_ascii_top.f -----
hdl/i2a_pkg.sv
hdl/i2a_in_if.sv
hdl/i2a_out_if.sv
hdl/i2a_datapath.sv
hdl/i2a_ctrl.sv
hdl/int32_to_decimal_ascii_top.sv
verif/tb_top.sv
